// ===== hdl/ps2mct_pkg.sv =====
// Package for the PS/2 mouse packet cursor tracker.
// Holds field widths, register indexes, reset values, the packet struct and
// the per-axis clamp function. No dependencies.
package ps2mct_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 10;
    localparam int EXTENT_W    = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int DELTA_W     = 10;   // negated 9-bit delta needs one more bit
    localparam int SUM_W       = 12;   // signed pos + delta

    localparam int QUEUE_DEPTH_DFLT = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [EXTENT_W-1:0] WIDTH_RST  = EXTENT_W'(320);
    localparam logic [EXTENT_W-1:0] HEIGHT_RST = EXTENT_W'(200);
    localparam logic [POS_W-1:0]    POS_X_RST  = POS_W'(160);
    localparam logic [POS_W-1:0]    POS_Y_RST  = POS_W'(100);
    localparam logic [EXTENT_W-1:0] EXTENT_MAX = EXTENT_W'(1024);

    // header bit positions
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int LEFT_BIT  = 0;
    localparam int RIGHT_BIT = 1;

    typedef struct packed {
        logic              x_sign;
        logic              y_sign;
        logic              left;
        logic              right;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } t_packet;

    // pos + delta, clamped to 0..lim-1 with lim forced into 1..1024
    function automatic logic [POS_W-1:0] clamp_axis(
        input logic [POS_W-1:0]          pos,
        input logic signed [DELTA_W-1:0] delta,
        input logic [EXTENT_W-1:0]       extent
    );
        logic [EXTENT_W-1:0]      lim;
        logic signed [SUM_W-1:0]  sum;
        logic [POS_W-1:0]         res;
        lim = extent;
        if (lim == '0) begin
            lim = EXTENT_W'(1);
        end else if (lim > EXTENT_MAX) begin
            lim = EXTENT_MAX;
        end
        sum = $signed({{(SUM_W-POS_W){1'b0}}, pos})
            + {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
        if (sum < 0) begin
            res = '0;
        end else if ($signed({1'b0, lim}) <= sum) begin
            res = POS_W'(lim - EXTENT_W'(1));
        end else begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ps2mct_if.sv =====
// Channel interfaces for the PS/2 mouse packet cursor tracker.
// Depends on ps2mct_pkg for field widths.
interface ps2mct_byte_if;
    logic                           valid;
    logic                           ready;
    logic [ps2mct_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mct_cursor_if;
    logic                           valid;
    logic                           ready;
    logic [ps2mct_pkg::POS_W-1:0]   cursor_x;
    logic [ps2mct_pkg::POS_W-1:0]   cursor_y;
    logic                           left_button;
    logic                           right_button;

    modport source (output valid, output cursor_x, output cursor_y,
                    output left_button, output right_button, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input left_button, input right_button, output ready);
endinterface

// ===== hdl/ps2mct_front.sv =====
// Front end: takes mouse bytes, keeps packet sync and assembles packets.
// Depends on ps2mct_pkg and ps2mct_byte_if.
module ps2mct_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2mct_byte_if.sink          i_rx,
    input  logic                 i_full,
    output logic                 o_push,
    output ps2mct_pkg::t_packet  o_pkt
);
    import ps2mct_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_XDATA,
        PH_YDATA
    } t_phase;

    t_phase              r_phase;
    logic [BYTE_W-1:0]   r_header;
    logic [BYTE_W-1:0]   r_xbyte;
    logic                w_accept;

    // only the closing byte needs room in the queue
    assign i_rx.ready = !((r_phase == PH_YDATA) && i_full);
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign o_push     = w_accept && (r_phase == PH_YDATA);

    assign o_pkt.x_sign = r_header[XSIGN_BIT];
    assign o_pkt.y_sign = r_header[YSIGN_BIT];
    assign o_pkt.left   = r_header[LEFT_BIT];
    assign o_pkt.right  = r_header[RIGHT_BIT];
    assign o_pkt.x_byte = r_xbyte;
    assign o_pkt.y_byte = i_rx.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_header <= '0;
            r_xbyte  <= '0;
        end else if (w_accept) begin
            unique case (r_phase)
                PH_XDATA: begin
                    r_xbyte <= i_rx.rx_byte;
                    r_phase <= PH_YDATA;
                end
                PH_YDATA: begin
                    r_phase <= PH_HEADER;
                end
                default: begin
                    // drop bytes without the always-one bit to regain sync
                    if (i_rx.rx_byte[SYNC_BIT]) begin
                        r_header <= i_rx.rx_byte;
                        r_phase  <= PH_XDATA;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/ps2mct_queue.sv =====
// Short packet queue between front and back end.
// Depends on ps2mct_pkg for the packet type.
module ps2mct_queue #(
    parameter int DEPTH = ps2mct_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ps2mct_pkg::t_packet  i_pkt,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output ps2mct_pkg::t_packet  o_pkt
);
    import ps2mct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_packet             r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                w_push;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_pkt   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
        end
    end

endmodule

// ===== hdl/ps2mct_back.sv =====
// Back end: applies packet deltas to the cursor, clamps to the screen and
// holds the result register. Depends on ps2mct_pkg and ps2mct_cursor_if.
module ps2mct_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  ps2mct_pkg::t_packet             i_pkt,
    input  logic [ps2mct_pkg::EXTENT_W-1:0] i_width,
    input  logic [ps2mct_pkg::EXTENT_W-1:0] i_height,
    output logic                            o_pop,
    ps2mct_cursor_if.source                 o_cursor
);
    import ps2mct_pkg::*;

    logic [POS_W-1:0]          r_pos_x;
    logic [POS_W-1:0]          r_pos_y;
    logic [POS_W-1:0]          n_pos_x;
    logic [POS_W-1:0]          n_pos_y;
    logic                      r_out_valid;
    logic                      r_left;
    logic                      r_right;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;

    // result register frees up when empty or when taken this cycle
    assign o_pop = i_valid && (!r_out_valid || o_cursor.ready);

    assign w_dx = {i_pkt.x_sign, i_pkt.x_sign, i_pkt.x_byte};
    // y grows upward on the mouse, downward on screen
    assign w_dy = -$signed({i_pkt.y_sign, i_pkt.y_sign, i_pkt.y_byte});

    assign n_pos_x = clamp_axis(r_pos_x, w_dx, i_width);
    assign n_pos_y = clamp_axis(r_pos_y, w_dy, i_height);

    assign o_cursor.valid        = r_out_valid;
    assign o_cursor.cursor_x     = r_pos_x;
    assign o_cursor.cursor_y     = r_pos_y;
    assign o_cursor.left_button  = r_left;
    assign o_cursor.right_button = r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= POS_X_RST;
            r_pos_y     <= POS_Y_RST;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_out_valid <= 1'b1;
        end else if (o_cursor.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_left  <= i_pkt.left;
            r_right <= i_pkt.right;
        end
    end

endmodule

// ===== hdl/ps2mct_regs.sv =====
// Screen extent registers written over the configuration port.
// Depends on ps2mct_pkg.
module ps2mct_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ps2mct_pkg::EXTENT_W-1:0]  i_cfg_data,
    output logic [ps2mct_pkg::EXTENT_W-1:0]  o_width,
    output logic [ps2mct_pkg::EXTENT_W-1:0]  o_height
);
    import ps2mct_pkg::*;

    logic [EXTENT_W-1:0] r_width;
    logic [EXTENT_W-1:0] r_height;

    assign o_width  = r_width;
    assign o_height = r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;  // unused indexes are ignored
            endcase
        end
    end

endmodule

// ===== hdl/ps2_mouse_packet_cursor_tracker_unit.sv =====
// Top level of the PS/2 mouse packet cursor tracker.
// Depends on ps2mct_pkg, ps2mct_if and the ps2mct_* submodules.
//
//  channel    dir  handshake        payload
//  i_rx       in   valid/ready      rx_byte[7:0]
//  o_cursor   out  valid/ready      cursor_x[9:0] cursor_y[9:0] left_button right_button
//  i_cfg_*    in   write enable     idx[1:0] (0 width, 1 height), data[10:0]
//
// One byte a cycle is taken unless a closing byte waits for queue room; the front end sets
// that rate, three bytes per packet. A result passes the queue, then the result register.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// The packet queue lets the front keep taking header and X bytes while the
// output stalls; only a closing Y byte waits for queue room.
module ps2_mouse_packet_cursor_tracker_unit #(
    parameter int QUEUE_DEPTH = ps2mct_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ps2mct_byte_if.sink                      i_rx,
    ps2mct_cursor_if.source                  o_cursor,
    input  logic                             i_cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ps2mct_pkg::EXTENT_W-1:0]  i_cfg_data
);
    import ps2mct_pkg::*;

    t_packet             w_push_pkt;
    t_packet             w_pop_pkt;
    logic                w_push;
    logic                w_pop;
    logic                w_q_valid;
    logic                w_q_full;
    logic [EXTENT_W-1:0] w_width;
    logic [EXTENT_W-1:0] w_height;

    ps2mct_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_width    (w_width),
        .o_height   (w_height)
    );

    ps2mct_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_pkt   (w_push_pkt)
    );

    ps2mct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_pkt   (w_pop_pkt)
    );

    ps2mct_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_pkt    (w_pop_pkt),
        .i_width  (w_width),
        .i_height (w_height),
        .o_pop    (w_pop),
        .o_cursor (o_cursor)
    );

endmodule
